[design/pos_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pos_pkg
// Shared types and constants for the process order scheduler.
// ---------------------------------------------------------------------------
package pos_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ARR_W   = 16;
  localparam int EXEC_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 20;
  localparam int PIDX_W  = 4;
  localparam int MODE_W  = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_FCFS = 2'd0;
  localparam mode_t MODE_SJF  = 2'd1;
  localparam mode_t MODE_PRIO = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // One stored process record as seen by the compare unit.
  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [EXEC_W-1:0] exec;
    logic [PRIO_W-1:0] prio;
  } proc_rec_t;

  // Result of one comparison step.
  typedef struct packed {
    logic better;
    logic arrived;
  } cmp_res_t;

endpackage
`default_nettype wire

[design/process_order_scheduler_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// process_order_scheduler_core
// Loads process records and emits a non-preemptive run order (FCFS, SJF or
// priority) with start and finish times.
// ---------------------------------------------------------------------------
// Channel   Signals                                           Handshake
// input     arrival_time, exec_time, prio_value, last_record  start & !busy
// config    cfg_data (sched_mode)                              cfg_valid & cfg_ready
// result    proc_index, start_time, finish_time, last_out     result_valid strobe
//
// A record that is not last is stored while the block is idle. The last record
// launches the schedule: each of the n results takes one scan of all n records
// through the shared compare unit followed by an emit state, and busy stays
// high for the whole batch. Results are registered, appearing in the cycle
// after their emit state, and cannot be stalled. Reset is synchronous and
// leaves the block empty with first come first served selected.
// ---------------------------------------------------------------------------
module process_order_scheduler_core import pos_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ARR_W-1:0]  arrival_time,
  input  wire logic [EXEC_W-1:0] exec_time,
  input  wire logic [PRIO_W-1:0] prio_value,
  input  wire logic              last_record,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MODE_W-1:0] cfg_data,
  output logic                   result_valid,
  output logic [PIDX_W-1:0]      proc_index,
  output logic [TIME_W-1:0]      start_time,
  output logic [TIME_W-1:0]      finish_time,
  output logic                   last_out
);

  logic [ARR_W-1:0]  arrival_table [MAX_PROCS];
  logic [EXEC_W-1:0] exec_table    [MAX_PROCS];
  logic [PRIO_W-1:0] prio_table    [MAX_PROCS];

  state_t state, state_next;

  mode_t               sched_mode;
  logic [MAX_PROCS-1:0] done_flags;
  logic [CNT_W-1:0]    record_count;
  logic [CNT_W-1:0]    emit_count;
  logic [IDX_W-1:0]    scan_idx;
  logic [TIME_W-1:0]   time_accum;

  logic              have_best;
  logic              best_arrived;
  logic [IDX_W-1:0]  best_idx;
  proc_rec_t         best_rec;

  proc_rec_t   cand_rec;
  cmp_res_t    cmp_res;
  logic        accept;
  logic        table_full;
  logic        launch;
  logic        scan_last;
  logic        emit_last;
  logic [TIME_W-1:0] finish_calc;

  assign accept     = start && !busy;
  assign table_full = record_count == CNT_W'(MAX_PROCS);
  assign launch     = accept && last_record;
  assign scan_last  = (CNT_W'(scan_idx) + CNT_W'(1)) == record_count;
  assign emit_last  = (emit_count + CNT_W'(1)) == record_count;
  assign finish_calc = time_accum + TIME_W'(best_rec.exec);

  assign cand_rec.arrival = arrival_table[scan_idx];
  assign cand_rec.exec    = exec_table[scan_idx];
  assign cand_rec.prio    = prio_table[scan_idx];

  pos_cmp u_cmp (
    .mode         (sched_mode),
    .now          (time_accum),
    .have_best    (have_best),
    .best_arrived (best_arrived),
    .cand         (cand_rec),
    .best         (best_rec),
    .res          (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    cfg_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
        if (launch) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_next = emit_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Record tables: written only while loading, no reset needed.
  always_ff @(posedge clk) begin
    if (accept && !table_full) begin
      arrival_table[record_count[IDX_W-1:0]] <= arrival_time;
      exec_table[record_count[IDX_W-1:0]]    <= exec_time;
      prio_table[record_count[IDX_W-1:0]]    <= prio_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode   <= MODE_FCFS;
      done_flags   <= '0;
      record_count <= '0;
      emit_count   <= '0;
      scan_idx     <= '0;
      time_accum   <= '0;
      have_best    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        sched_mode <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && !table_full) begin
            record_count <= record_count + CNT_W'(1);
          end
          done_flags <= '0;
          emit_count <= '0;
          scan_idx   <= '0;
          time_accum <= '0;
          have_best  <= 1'b0;
        end
        ST_SCAN: begin
          // Entries already scheduled are skipped; ties keep the lower index.
          if (!done_flags[scan_idx] && cmp_res.better) begin
            have_best    <= 1'b1;
            best_arrived <= cmp_res.arrived;
            best_idx     <= scan_idx;
            best_rec     <= cand_rec;
          end
          if (!scan_last) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          result_valid         <= 1'b1;
          proc_index           <= PIDX_W'(best_idx);
          start_time           <= time_accum;
          finish_time          <= finish_calc;
          last_out             <= emit_last;
          done_flags[best_idx] <= 1'b1;
          time_accum           <= finish_calc;
          emit_count           <= emit_count + CNT_W'(1);
          scan_idx             <= '0;
          have_best            <= 1'b0;
          if (emit_last) begin
            record_count <= '0;
          end
        end
        default: begin
          have_best <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/pos_cmp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pos_cmp
// Compare unit: decides whether a candidate record beats the current best
// under the selected ordering rule.
// ---------------------------------------------------------------------------
module pos_cmp import pos_pkg::*; (
  input  wire mode_t           mode,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic            have_best,
  input  wire logic            best_arrived,
  input  wire proc_rec_t       cand,
  input  wire proc_rec_t       best,
  output cmp_res_t             res
);

  logic arr_lt;
  logic cand_arrived;

  assign arr_lt       = cand.arrival < best.arrival;
  assign cand_arrived = TIME_W'(cand.arrival) <= now;

  always_comb begin
    res.arrived = cand_arrived;
    if (!have_best) begin
      res.better = 1'b1;
    end else begin
      unique case (mode)
        MODE_PRIO: res.better = cand.prio < best.prio;
        MODE_SJF: begin
          // An arrived job always beats one that has not arrived yet.
          if (cand_arrived != best_arrived) begin
            res.better = cand_arrived;
          end else if (cand_arrived) begin
            res.better = cand.exec < best.exec;
          end else begin
            res.better = arr_lt;
          end
        end
        default: res.better = arr_lt;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/sv/process_order_scheduler_core_tb.sv]
// ---------------------------------------------------------------------------
// process_order_scheduler_core_tb
// Loads batches of process records into the scheduler under every ordering
// mode and checks each emitted run slot against a local schedule predictor.
// ---------------------------------------------------------------------------
module process_order_scheduler_core_tb;
  import pos_pkg::*;

  localparam mode_t MODE_UNUSED   = 2'd3;
  localparam int    GAP_PCT       = 13;
  localparam int    SETTLE_CYCLES = 40;
  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    PHASE_ITEMS   = 56;

  typedef struct {
    logic [ARR_W-1:0]  arr;
    logic [EXEC_W-1:0] exe;
    logic [PRIO_W-1:0] pri;
    logic              fin;
  } proc_rec_item_t;

  typedef struct {
    logic [PIDX_W-1:0] idx;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_done;
    logic              fin_flag;
  } run_slot_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic [ARR_W-1:0]  arrival_time = '0;
  logic [EXEC_W-1:0] exec_time    = '0;
  logic [PRIO_W-1:0] prio_value   = '0;
  logic              last_record  = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic [MODE_W-1:0] cfg_data     = '0;
  logic              busy;
  logic              cfg_ready;
  logic              result_valid;
  logic [PIDX_W-1:0] proc_index;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] finish_time;
  logic              last_out;

  proc_rec_item_t pending_recs[$];
  run_slot_t      sched_expect[$];

  // Predictor state: stored batch and the active ordering rule.
  logic [ARR_W-1:0]  arr_tab [MAX_PROCS];
  logic [EXEC_W-1:0] exe_tab [MAX_PROCS];
  logic [PRIO_W-1:0] pri_tab [MAX_PROCS];
  int                stored_cnt  = 0;
  mode_t             active_mode = MODE_FCFS;

  int fed_cnt      = 0;
  int batch_cnt    = 0;
  int dropped_cnt  = 0;
  int slots_seen   = 0;
  int err_cnt      = 0;
  int cfg_writes   = 0;
  int cycle_cnt    = 0;

  process_order_scheduler_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .arrival_time (arrival_time),
    .exec_time    (exec_time),
    .prio_value   (prio_value),
    .last_record  (last_record),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .proc_index   (proc_index),
    .start_time   (start_time),
    .finish_time  (finish_time),
    .last_out     (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the full run order of the stored batch and queues its slots.
  function automatic void predict_run_order();
    bit                taken [MAX_PROCS];
    logic [TIME_W-1:0] now;
    int                best;
    bit                have;
    bit                best_arr;
    bit                arr;
    bit                better;
    run_slot_t         slot;
    now = '0;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int k = 0; k < stored_cnt; k++) begin
      have     = 1'b0;
      best     = 0;
      best_arr = 1'b0;
      for (int i = 0; i < stored_cnt; i++) begin
        if (!taken[i]) begin
          arr = (arr_tab[i] <= now);
          if (!have) begin
            better = 1'b1;
          end else if (active_mode == MODE_PRIO) begin
            better = pri_tab[i] < pri_tab[best];
          end else if (active_mode == MODE_SJF) begin
            // Arrived jobs beat waiting ones; waiting ones go by arrival.
            if (arr != best_arr) better = arr;
            else if (arr) better = exe_tab[i] < exe_tab[best];
            else better = arr_tab[i] < arr_tab[best];
          end else begin
            better = arr_tab[i] < arr_tab[best];
          end
          if (better) begin
            best     = i;
            best_arr = arr;
            have     = 1'b1;
          end
        end
      end
      taken[best]   = 1'b1;
      slot.idx      = best[PIDX_W-1:0];
      slot.t_start  = now;
      now           = now + exe_tab[best];
      slot.t_done   = now;
      slot.fin_flag = (k == stored_cnt - 1);
      sched_expect  = {sched_expect, slot};
    end
    stored_cnt = 0;
    batch_cnt++;
  endfunction

  function automatic void store_record(proc_rec_item_t rec);
    if (stored_cnt < MAX_PROCS) begin
      arr_tab[stored_cnt] = rec.arr;
      exe_tab[stored_cnt] = rec.exe;
      pri_tab[stored_cnt] = rec.pri;
      stored_cnt++;
    end else begin
      dropped_cnt++;
    end
    if (rec.fin) predict_run_order();
  endfunction

  function automatic void queue_record(logic [ARR_W-1:0] arr, logic [EXEC_W-1:0] exe,
                                       logic [PRIO_W-1:0] pri, logic fin);
    proc_rec_item_t rec;
    rec.arr = arr;
    rec.exe = exe;
    rec.pri = pri;
    rec.fin = fin;
    pending_recs = {pending_recs, rec};
  endfunction

  // One random batch; the style picks value ranges that stress a given rule.
  function automatic int queue_random_batch();
    int n;
    int style;
    int pick;
    pick  = $urandom_range(0, 19);
    style = $urandom_range(0, 9);
    if (pick < 2) n = MAX_PROCS;
    else if (pick < 4) n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
    else n = $urandom_range(1, MAX_PROCS);
    for (int i = 0; i < n; i++) begin
      if (style < 4) begin
        queue_record($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 255), i == n - 1);
      end else if (style < 7) begin
        // Arrivals spread over the span of the run so SJF sees waiting jobs.
        queue_record($urandom_range(0, 1200), $urandom_range(0, 150),
                     $urandom_range(0, 255), i == n - 1);
      end else begin
        queue_record($urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 2), i == n - 1);
      end
    end
    return n;
  endfunction

  // Driver: presents queued records, with random gaps outside a quiet window.
  always @(posedge clk) begin : drive_records
    proc_rec_item_t nxt;
    bit             hold_off;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nxt.arr = arrival_time;
        nxt.exe = exec_time;
        nxt.pri = prio_value;
        nxt.fin = last_record;
        store_record(nxt);
        fed_cnt++;
      end
      if (!start || !busy) begin
        hold_off = !(fed_cnt >= 180 && fed_cnt < 300) && ($urandom_range(0, 99) < GAP_PCT);
        if (pending_recs.size() != 0 && !hold_off) begin
          nxt = pending_recs.pop_front();
          arrival_time <= nxt.arr;
          exec_time    <= nxt.exe;
          prio_value   <= nxt.pri;
          last_record  <= nxt.fin;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed slot is matched against the oldest expectation.
  always @(posedge clk) begin : check_slots
    run_slot_t exp_slot;
    if (!rst && result_valid) begin
      if (sched_expect.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected slot: idx=%0d start=%0d finish=%0d last=%0b",
                   proc_index, start_time, finish_time, last_out);
      end else begin
        exp_slot = sched_expect.pop_front();
        slots_seen++;
        if (proc_index !== exp_slot.idx || start_time !== exp_slot.t_start ||
            finish_time !== exp_slot.t_done || last_out !== exp_slot.fin_flag) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"slot mismatch: exp idx=%0d start=%0d finish=%0d last=%0b, ",
                      "got idx=%0d start=%0d finish=%0d last=%0b"},
                     exp_slot.idx, exp_slot.t_start, exp_slot.t_done, exp_slot.fin_flag,
                     proc_index, start_time, finish_time, last_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slots still expected",
               cycle_cnt, sched_expect.size());
      $display("process_order_scheduler_core verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_recs.size() != 0 || start || sched_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    active_mode  = m;
    cfg_writes++;
  endtask

  initial begin : run_phases
    mode_t phase_modes [7];
    int    added;
    phase_modes = '{MODE_SJF, MODE_PRIO, MODE_UNUSED, MODE_FCFS, MODE_SJF,
                    MODE_PRIO, MODE_FCFS};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed batches: single records at both extremes, ties, a full table.
    queue_record(16'd0, 16'd0, 8'd0, 1'b1);
    queue_record(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    queue_record(16'd5, 16'd10, 8'd3, 1'b0);
    queue_record(16'd5, 16'd10, 8'd3, 1'b0);
    queue_record(16'd0, 16'hFFFF, 8'hFF, 1'b0);
    queue_record(16'hFFFF, 16'd0, 8'd0, 1'b1);
    for (int i = 0; i < MAX_PROCS; i++)
      queue_record(16'hFFFF - 16'(i), 16'hFFFF, 8'(i), 1'b0);
    // This record overflows the table but still launches the schedule.
    queue_record(16'h1234, 16'h0001, 8'h00, 1'b1);
    wait_drained();

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      added = 0;
      while (added < PHASE_ITEMS) added += queue_random_batch();
      wait_drained();
    end

    $display("covered %0d records in %0d batches (%0d dropped on a full table)",
             fed_cnt, batch_cnt, dropped_cnt);
    $display("slots checked: %0d, mode writes: %0d, mismatches: %0d, leftover slots: %0d",
             slots_seen, cfg_writes, err_cnt, sched_expect.size());
    if (err_cnt == 0 && sched_expect.size() == 0) begin
      $display("process_order_scheduler_core verification clean");
    end else begin
      $display("process_order_scheduler_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/pos_pkg.sv
design/pos_cmp.sv
design/process_order_scheduler_core.sv
tb/sv/process_order_scheduler_core_tb.sv
